FILE: sv/irfu_pkg.sv
// Shared constants, register indexes and controller/datapath interface types.
package irfu_pkg;

    localparam int FRAME_DEPTH_DEF = 64;

    localparam logic [7:0] BEGIN_CODE_RST  = 8'hC0;
    localparam logic [7:0] END_CODE_RST    = 8'hC1;
    localparam logic [7:0] ESCAPE_CODE_RST = 8'h7D;
    localparam logic [7:0] ESC_XOR         = 8'h20;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_BEGIN  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_END    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ESCAPE = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic restart;  // start a new frame with this byte at entry zero
        logic put;      // append this byte to the frame store
        logic xor_en;   // byte follows an escape and is flipped before storing
        logic drain;    // frame is being read out
        logic clear;    // readout finished, empty the store
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic hit_begin;
        logic hit_end;
        logic hit_escape;
        logic drain_done;
    } t_dp_status;

endpackage

FILE: sv/irfu_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module irfu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]  i_wr_data,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [WIDTH-1:0]  o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: sv/irfu_ctrl.sv
// Receive phase state machine that issues store and drain commands.
module irfu_ctrl
    import irfu_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_BEGIN  = 3'd1;
    localparam logic [2:0] S_ESCAPE = 3'd2;
    localparam logic [2:0] S_DATA   = 3'd3;
    localparam logic [2:0] S_DRAIN  = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic       accept;

    assign o_in_stall = (r_state == S_DRAIN);
    assign accept     = i_in_valid && !o_in_stall;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.drain = (r_state == S_DRAIN);
        case (r_state)
            S_IDLE: begin
                if (accept && i_status.hit_begin) begin
                    o_cmd.restart = 1'b1;
                    n_state = S_BEGIN;
                end
            end
            S_BEGIN: begin
                if (accept) begin
                    if (i_status.hit_begin) begin
                        o_cmd.restart = 1'b1;
                    end else if (i_status.hit_escape) begin
                        n_state = S_ESCAPE;
                    end else if (i_status.hit_end) begin
                        n_state = S_IDLE;
                    end else begin
                        o_cmd.put = 1'b1;
                        n_state = S_DATA;
                    end
                end
            end
            S_ESCAPE: begin
                if (accept) begin
                    if (i_status.hit_begin) begin
                        o_cmd.restart = 1'b1;
                        n_state = S_BEGIN;
                    end else if (i_status.hit_end) begin
                        n_state = S_IDLE;
                    end else begin
                        o_cmd.put    = 1'b1;
                        o_cmd.xor_en = 1'b1;
                        n_state = S_DATA;
                    end
                end
            end
            S_DATA: begin
                if (accept) begin
                    if (i_status.hit_escape) begin
                        n_state = S_ESCAPE;
                    end else if (i_status.hit_begin) begin
                        o_cmd.restart = 1'b1;
                        n_state = S_BEGIN;
                    end else if (i_status.hit_end) begin
                        o_cmd.put = 1'b1;
                        n_state = S_DRAIN;
                    end else begin
                        o_cmd.put = 1'b1;
                    end
                end
            end
            S_DRAIN: begin
                if (i_status.drain_done) begin
                    o_cmd.clear = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

`ifndef SYNTHESIS
    // A readout only ends by returning to idle.
    a_drain_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DRAIN && i_status.drain_done) |=> (r_state == S_IDLE))
        else $error("drain did not return to idle");
`endif

endmodule

FILE: sv/irfu_dp.sv
// Datapath: code registers, frame store, fill tracking and the output register.
module irfu_dp
    import irfu_pkg::*;
#(
    parameter int FRAME_DEPTH = FRAME_DEPTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [7:0]           i_cfg_data,
    input  logic [7:0]           i_rx_byte,
    input  t_dp_cmd              i_cmd,
    output t_dp_status           o_status,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [7:0]           o_frame_byte,
    output logic                 o_last_of_frame,
    output logic                 o_frame_truncated
);

    localparam int ADDR_W = $clog2(FRAME_DEPTH);
    localparam int CNT_W  = $clog2(FRAME_DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(FRAME_DEPTH);
    localparam logic [CNT_W-1:0] CNT_ONE   = CNT_W'(1);

    logic [7:0]       r_begin_code;
    logic [7:0]       r_end_code;
    logic [7:0]       r_escape_code;
    logic [CNT_W-1:0] r_fill;
    logic [CNT_W-1:0] n_fill;
    logic             r_ovf;
    logic             n_ovf;
    logic [CNT_W-1:0] r_rd_cnt;
    logic [CNT_W-1:0] n_rd_cnt;
    logic             r_pend;
    logic             r_pend_last;
    logic             r_out_valid;
    logic [7:0]       r_out_byte;
    logic             r_out_last;
    logic             r_out_trunc;

    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [7:0]        wr_data;
    logic              rd_en;
    logic [7:0]        rd_data;

    assign o_status.hit_begin  = (i_rx_byte == r_begin_code);
    assign o_status.hit_end    = (i_rx_byte == r_end_code);
    assign o_status.hit_escape = (i_rx_byte == r_escape_code);
    assign o_status.drain_done = (r_rd_cnt == r_fill) && !r_pend;

    // A read is issued only when the output register is free by the next cycle.
    assign rd_en = i_cmd.drain && !r_pend && (r_rd_cnt != r_fill)
                   && (!r_out_valid || !i_out_stall);

    always_comb begin
        wr_en    = 1'b0;
        wr_addr  = r_fill[ADDR_W-1:0];
        wr_data  = i_cmd.xor_en ? (i_rx_byte ^ ESC_XOR) : i_rx_byte;
        n_fill   = r_fill;
        n_ovf    = r_ovf;
        n_rd_cnt = rd_en ? r_rd_cnt + CNT_ONE : r_rd_cnt;
        if (i_cmd.restart) begin
            wr_en   = 1'b1;
            wr_addr = '0;
            n_fill  = CNT_ONE;
            n_ovf   = 1'b0;
        end else if (i_cmd.put) begin
            if (r_fill < DEPTH_CNT) begin
                wr_en  = 1'b1;
                n_fill = r_fill + CNT_ONE;
            end else begin
                n_ovf = 1'b1;
            end
        end
        if (i_cmd.clear) begin
            n_fill   = '0;
            n_ovf    = 1'b0;
            n_rd_cnt = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_begin_code  <= BEGIN_CODE_RST;
            r_end_code    <= END_CODE_RST;
            r_escape_code <= ESCAPE_CODE_RST;
            r_fill        <= '0;
            r_ovf         <= 1'b0;
            r_rd_cnt      <= '0;
            r_pend        <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_BEGIN:  r_begin_code  <= i_cfg_data;
                    CFG_END:    r_end_code    <= i_cfg_data;
                    CFG_ESCAPE: r_escape_code <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            r_fill      <= n_fill;
            r_ovf       <= n_ovf;
            r_rd_cnt    <= n_rd_cnt;
            r_pend      <= rd_en;
            r_out_valid <= r_pend || (r_out_valid && i_out_stall);
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_pend_last <= (r_rd_cnt + CNT_ONE == r_fill);
        end
        if (r_pend) begin
            r_out_byte  <= rd_data;
            r_out_last  <= r_pend_last;
            r_out_trunc <= r_ovf;
        end
    end

    irfu_ram #(
        .WIDTH (8),
        .DEPTH (FRAME_DEPTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (r_rd_cnt[ADDR_W-1:0]),
        .o_rd_data (rd_data)
    );

    assign o_out_valid       = r_out_valid;
    assign o_frame_byte      = r_out_byte;
    assign o_last_of_frame   = r_out_last;
    assign o_frame_truncated = r_out_trunc;

`ifndef SYNTHESIS
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= DEPTH_CNT)
        else $error("fill count beyond store depth");

    a_rd_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_cnt <= r_fill)
        else $error("read pointer passed fill count");

    a_pend_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> !r_out_valid)
        else $error("read data arrived while output register was full");
`endif

endmodule

FILE: sv/ir_async_frame_unstuffer_core.sv
// Top level of the asynchronous infrared frame receiver and unstuffer.
//
// This block takes received UART bytes, one request per byte, and tracks the
// asynchronous receive framing: a begin byte opens (or reopens) a frame, an
// escape byte is dropped and makes the following byte be stored with bit 5
// flipped, and an end byte closes the frame. An end byte right after a begin
// or an escape aborts the frame without any output. When a frame closes, the
// whole frame, begin and end bytes included, is sent out as a burst of output
// requests; the last one carries last_of_frame, and every one of them carries
// frame_truncated if bytes were dropped because the FRAME_DEPTH byte store
// filled up. While receiving, one byte is taken every clock cycle. Once an end
// byte is taken, input is stalled while the frame is read back through the
// store's registered read port and a single output register; a new read is
// issued only once the previous read's data has reached the output register.
// Input reopens once the last byte has reached the output register and the
// store is cleared, while the final output request may still wait to be
// taken. The three code registers are written through a simple write port
// and should only change while the block is idle.
module ir_async_frame_unstuffer_core
    import irfu_pkg::*;
#(
    parameter int FRAME_DEPTH = FRAME_DEPTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // Configuration write port.
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [7:0]           i_cfg_data,
    // Input byte channel.
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [7:0]           i_rx_byte,
    // Output frame channel.
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [7:0]           o_frame_byte,
    output logic                 o_last_of_frame,
    output logic                 o_frame_truncated
);

    t_dp_cmd    cmd;
    t_dp_status status;

    // The controller owns the receive phase and decides what each byte does.
    irfu_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    // The datapath holds the codes, the frame store and the output register.
    irfu_dp #(
        .FRAME_DEPTH (FRAME_DEPTH)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_idx         (i_cfg_idx),
        .i_cfg_data        (i_cfg_data),
        .i_rx_byte         (i_rx_byte),
        .i_cmd             (cmd),
        .o_status          (status),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_frame_byte      (o_frame_byte),
        .o_last_of_frame   (o_last_of_frame),
        .o_frame_truncated (o_frame_truncated)
    );

endmodule

FILE: verif/irfu_tb_pkg.sv
// Frame scoreboard for the infrared frame unstuffer: receive state and expected output bytes.
package irfu_tb_pkg;
    import irfu_pkg::*;

    // Index that maps to no register; a write to it must change nothing.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    typedef enum logic [1:0] {
        RX_IDLE,
        RX_AFTER_BEGIN,
        RX_AFTER_ESCAPE,
        RX_IN_DATA
    } t_rx_phase;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       truncated;
    } t_frame_beat;

    class frame_scoreboard;
        logic [7:0]  begin_code;
        logic [7:0]  end_code;
        logic [7:0]  escape_code;
        t_rx_phase   phase;
        logic [7:0]  store [FRAME_DEPTH_DEF];
        int unsigned fill;
        bit          dropped;
        t_frame_beat expected_beats [$];
        int unsigned errors;

        function new();
            begin_code  = BEGIN_CODE_RST;
            end_code    = END_CODE_RST;
            escape_code = ESCAPE_CODE_RST;
            phase       = RX_IDLE;
            fill        = 0;
            dropped     = 1'b0;
            errors      = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [7:0] value);
            case (idx)
                CFG_BEGIN:  begin_code  = value;
                CFG_END:    end_code    = value;
                CFG_ESCAPE: escape_code = value;
                default: ;
            endcase
        endfunction

        function void append(logic [7:0] value);
            if (fill < FRAME_DEPTH_DEF) begin
                store[fill] = value;
                fill++;
            end else begin
                dropped = 1'b1;
            end
        endfunction

        function void open_frame(logic [7:0] value);
            fill    = 0;
            dropped = 1'b0;
            append(value);
            phase   = RX_AFTER_BEGIN;
        endfunction

        function void release_frame();
            t_frame_beat beat;
            for (int unsigned k = 0; k < fill; k++) begin
                beat.data      = store[k];
                beat.last      = (k + 1 == fill);
                beat.truncated = dropped;
                expected_beats.push_back(beat);
            end
            fill    = 0;
            dropped = 1'b0;
            phase   = RX_IDLE;
        endfunction

        // The order of the code tests differs per phase; the first match wins.
        function void note_byte(logic [7:0] value);
            case (phase)
                RX_IDLE: begin
                    if (value == begin_code) open_frame(value);
                end
                RX_AFTER_BEGIN: begin
                    if (value == begin_code) begin
                        open_frame(value);
                    end else if (value == escape_code) begin
                        phase = RX_AFTER_ESCAPE;
                    end else if (value == end_code) begin
                        phase = RX_IDLE;
                    end else begin
                        append(value);
                        phase = RX_IN_DATA;
                    end
                end
                RX_AFTER_ESCAPE: begin
                    if (value == begin_code) begin
                        open_frame(value);
                    end else if (value == end_code) begin
                        phase = RX_IDLE;
                    end else begin
                        append(value ^ ESC_XOR);
                        phase = RX_IN_DATA;
                    end
                end
                default: begin
                    if (value == escape_code) begin
                        phase = RX_AFTER_ESCAPE;
                    end else if (value == begin_code) begin
                        open_frame(value);
                    end else if (value == end_code) begin
                        append(value);
                        release_frame();
                    end else begin
                        append(value);
                    end
                end
            endcase
        endfunction

        function void report(string what, realtime stamp, logic [7:0] want, logic [7:0] got);
            $display("[%0.1f ns] %s mismatch: expected %02h, actual %02h",
                     stamp, what, want, got);
            errors++;
        endfunction

        function void check_beat(logic [7:0] data, logic last, logic truncated, realtime stamp);
            t_frame_beat want;
            if (expected_beats.size() == 0) begin
                $display("[%0.1f ns] unexpected output byte %02h: expected none, actual %02h",
                         stamp, data, data);
                errors++;
                return;
            end
            want = expected_beats.pop_front();
            if (data !== want.data) report("frame_byte", stamp, want.data, data);
            if (last !== want.last) report("last_of_frame", stamp, want.last, last);
            if (truncated !== want.truncated)
                report("frame_truncated", stamp, want.truncated, truncated);
        endfunction

        function int unsigned pending();
            return expected_beats.size();
        endfunction
    endclass

endpackage

FILE: verif/testbench.sv
// Top-level testbench for the asynchronous infrared frame unstuffer core.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import irfu_pkg::*;
    import irfu_tb_pkg::*;

    // Each side idles in roughly this percentage of cycles.
    localparam int unsigned IDLE_PCT     = 37;
    // Length of the long output hold-off used to back the block up.
    localparam int unsigned HOLD_CYCLES  = 400;
    // Quiet cycles after the last result, covering bytes that produce no output.
    localparam int unsigned QUIET_CYCLES = 10;
    // Far above the slowest legal run, including worst-case stalls on both sides.
    localparam int unsigned CYCLE_LIMIT  = 200000;

    // How a generated frame ends.
    localparam int unsigned CLOSE_CLEAN = 0;
    localparam int unsigned CLOSE_ABORT = 1;
    localparam int unsigned CLOSE_NOISE = 2;

    logic       clk             = 1'b0;
    logic       rst_n           = 1'b0;
    logic       cfg_we          = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_idx = CFG_BEGIN;
    logic [7:0] cfg_data        = 8'h00;
    logic       in_valid        = 1'b0;
    logic       in_stall;
    logic [7:0] rx_byte         = 8'h00;
    logic       out_valid;
    logic       out_stall       = 1'b0;
    logic [7:0] frame_byte;
    logic       last_of_frame;
    logic       frame_truncated;

    // Idling switches, written by the stimulus process at falling edges.
    bit          tx_idle_on    = 1'b1;
    bit          rx_idle_on    = 1'b1;
    // The stimulus bumps hold_requests; the receiver process serves each request once.
    int unsigned hold_requests = 0;
    int unsigned holds_served  = 0;
    int unsigned hold_left     = 0;
    int unsigned items_sent    = 0;
    int unsigned cycle_count   = 0;

    frame_scoreboard frame_check = new();

    // Opening sequence under the reset codes: two bytes ignored while idle, a frame
    // with the extreme data values and two escaped bytes (one turning into the
    // escape code itself, one into the begin code), an abort right after begin,
    // an abort right after escape, a begin that restarts from the escape phase
    // followed by an escaped escape byte, then begin after begin and begin in data.
    logic [7:0] opening_bytes [$] = '{
        ESCAPE_CODE_RST, 8'h12,
        BEGIN_CODE_RST, 8'h00, 8'hFF, ESCAPE_CODE_RST, 8'h5D, ESCAPE_CODE_RST, 8'hE0,
        END_CODE_RST,
        BEGIN_CODE_RST, END_CODE_RST,
        BEGIN_CODE_RST, ESCAPE_CODE_RST, END_CODE_RST,
        BEGIN_CODE_RST, ESCAPE_CODE_RST, BEGIN_CODE_RST, ESCAPE_CODE_RST,
        ESCAPE_CODE_RST, END_CODE_RST,
        BEGIN_CODE_RST, BEGIN_CODE_RST, 8'h11, BEGIN_CODE_RST, 8'h22, END_CODE_RST
    };

    ir_async_frame_unstuffer_core dut (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_cfg_we          (cfg_we),
        .i_cfg_idx         (cfg_idx),
        .i_cfg_data        (cfg_data),
        .i_in_valid        (in_valid),
        .o_in_stall        (in_stall),
        .i_rx_byte         (rx_byte),
        .o_out_valid       (out_valid),
        .i_out_stall       (out_stall),
        .o_frame_byte      (frame_byte),
        .o_last_of_frame   (last_of_frame),
        .o_frame_truncated (frame_truncated)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    // Receiver stall pattern. A hold-off request forces stall high through the long
    // hold-off; otherwise stall follows the random idling rate.
    always @(negedge clk) begin
        if (hold_requests != holds_served) begin
            holds_served = hold_requests;
            hold_left    = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            out_stall <= 1'b1;
            hold_left--;
        end else begin
            out_stall <= rx_idle_on && ($urandom_range(99) < IDLE_PCT);
        end
    end

    // Every accepted output request is checked against the oldest expected byte.
    // Inputs only move at falling edges, so the values seen here are the ones
    // the block saw at this rising edge.
    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall)
            frame_check.check_beat(frame_byte, last_of_frame, frame_truncated, $realtime);
    end

    // Watchdog: a hung handshake or a lost byte ends the run here.
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("testbench failed");
            $finish;
        end
    end

    // Offers one byte and holds it until the block takes it. Entered and left
    // at a falling edge; the valid line is assigned at most once per edge, so a
    // byte that follows directly keeps valid high without a glitch.
    task automatic send_byte(input logic [7:0] value);
        while (tx_idle_on && $urandom_range(99) < IDLE_PCT) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= value;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        frame_check.note_byte(value);
        items_sent++;
        @(negedge clk);
    endtask

    // Sends frame payload that never hits begin or end by accident. Some bytes
    // go out escaped, so the stored value is flipped and may equal any code.
    task automatic send_payload(input int unsigned count);
        logic [7:0] value;
        repeat (count) begin
            do value = 8'($urandom_range(255));
            while (value == frame_check.begin_code || value == frame_check.end_code);
            if (value == frame_check.escape_code || $urandom_range(6) == 0) begin
                send_byte(frame_check.escape_code);
                send_byte(value);
            end else begin
                send_byte(value);
            end
        end
    endtask

    task automatic offer_frame(input int unsigned count, input int unsigned closing);
        send_byte(frame_check.begin_code);
        send_payload(count);
        case (closing)
            CLOSE_ABORT: begin
                send_byte(frame_check.escape_code);
                send_byte(frame_check.end_code);
            end
            CLOSE_NOISE: send_byte(8'($urandom_range(255)));
            default:     send_byte(frame_check.end_code);
        endcase
    endtask

    // Mostly well-formed short frames with random content, some longer ones,
    // and a share of aborted or broken frames and loose noise bytes.
    task automatic random_traffic(input int unsigned budget);
        int unsigned stop_at = items_sent + budget;
        int unsigned pick;
        while (items_sent < stop_at) begin
            pick = $urandom_range(99);
            if (pick < 70) begin
                offer_frame($urandom_range(6), CLOSE_CLEAN);
            end else if (pick < 78) begin
                offer_frame($urandom_range(30, 12), CLOSE_CLEAN);
            end else if (pick < 90) begin
                offer_frame($urandom_range(6),
                            ($urandom_range(1) == 0) ? CLOSE_ABORT : CLOSE_NOISE);
            end else begin
                repeat ($urandom_range(3, 1)) send_byte(8'($urandom_range(255)));
            end
        end
    endtask

    // The sender stops and waits until every expected byte has come out.
    task automatic wait_for_results();
        in_valid <= 1'b0;
        do @(negedge clk);
        while (frame_check.pending() != 0);
    endtask

    // Waits for the block to go quiet, then rewrites all code registers,
    // plus the unused index, which must leave everything unchanged.
    task automatic program_codes(input logic [7:0] begin_val, input logic [7:0] end_val,
                                 input logic [7:0] escape_val);
        wait_for_results();
        repeat (QUIET_CYCLES) @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= CFG_BEGIN;
        cfg_data <= begin_val;
        frame_check.write_reg(CFG_BEGIN, begin_val);
        @(negedge clk);
        cfg_idx  <= CFG_END;
        cfg_data <= end_val;
        frame_check.write_reg(CFG_END, end_val);
        @(negedge clk);
        cfg_idx  <= CFG_ESCAPE;
        cfg_data <= escape_val;
        frame_check.write_reg(CFG_ESCAPE, escape_val);
        @(negedge clk);
        cfg_idx  <= CFG_SPARE;
        cfg_data <= 8'($urandom_range(255));
        @(negedge clk);
        cfg_we   <= 1'b0;
        @(negedge clk);
    endtask

    initial begin
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset codes: directed cases first, then random traffic with idling.
        foreach (opening_bytes[i]) send_byte(opening_bytes[i]);
        random_traffic(6);

        // Back-pressure: the receiver holds off for a long stretch while the
        // sender keeps going. The store fills before the last payload byte of
        // the first frame, so that byte and the end byte are dropped and the
        // frame is marked truncated; the next frame waits behind the readout.
        hold_requests <= hold_requests + 1;
        offer_frame(FRAME_DEPTH_DEF, CLOSE_CLEAN);
        offer_frame(2, CLOSE_CLEAN);
        wait_for_results();

        // From here on neither side idles.
        tx_idle_on <= 1'b0;
        rx_idle_on <= 1'b0;

        // Begin and escape share one value: in data the escape test wins, while
        // after begin or escape the begin test wins.
        program_codes(8'hFF, 8'h00, 8'hFF);
        send_byte(8'hFF);
        send_byte(8'hFF);
        send_byte(8'h11);
        send_byte(8'hFF);
        send_byte(8'hFF);
        send_byte(8'h33);
        send_byte(8'h00);

        // End and escape share one value: after begin it acts as escape, after
        // escape it aborts, and in data it can never close a frame.
        program_codes(8'h7E, 8'h7D, 8'h7D);
        send_byte(8'h7E);
        send_byte(8'h7D);
        send_byte(8'h7D);
        send_byte(8'h7E);
        send_byte(8'h44);
        send_byte(8'h7D);
        send_byte(8'h55);

        // Reset codes again, still with no idling on either side.
        program_codes(BEGIN_CODE_RST, END_CODE_RST, ESCAPE_CODE_RST);
        random_traffic(15);

        wait_for_results();
        repeat (QUIET_CYCLES) @(negedge clk);
        if (frame_check.errors == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end

endmodule
